@@ sv/arbp_pkg.sv @@
// ----------------------------------------------------------------------------
// arbp_pkg
// shared types, widths and segment coding for the action record bit packer
// ----------------------------------------------------------------------------
package arbp_pkg;

  localparam int WORD_W   = 32;
  localparam int NUM_AXIS = 9;
  localparam int NUM_SEG  = NUM_AXIS + 1;
  localparam int SEG_W    = 38;
  localparam int LEN_W    = 6;
  localparam int ACC_W    = 54;
  localparam int CNT_W    = 6;
  localparam int SIDX_W   = 4;
  localparam int IN_W     = 352;

  typedef struct packed {
    logic [SEG_W-1:0] bits;
    logic [LEN_W-1:0] len;
  } seg_t;

  typedef struct packed {
    logic capture;
    logic emit_partial;
    logic emit_created;
    logic emit_acc;
    logic load_seg;
    logic sel_button;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic held;
    logic out_free;
    logic acc_lt16;
    logic acc_ge8;
  } dp_status_t;

  function automatic seg_t axis_seg(input logic [WORD_W-1:0] w);
    seg_t s;
    s.bits = '0;
    s.len  = LEN_W'(1);
    if (w != '0) begin
      s.bits = SEG_W'({w, 1'b1});
      s.len  = LEN_W'(33);
    end
    return s;
  endfunction

  function automatic seg_t button_seg(input logic [WORD_W-1:0] f);
    seg_t s;
    s.bits = '0;
    s.len  = '0;
    if (f == '0) begin
      s.bits = SEG_W'(1);
      s.len  = LEN_W'(1);
    end else if (f == WORD_W'(1)) begin
      s.bits = SEG_W'(2);
      s.len  = LEN_W'(2);
    end else if (f <= WORD_W'(3)) begin
      s.bits = SEG_W'({f[0], 3'b100});
      s.len  = LEN_W'(4);
    end else if (f <= WORD_W'(15)) begin
      s.bits = SEG_W'({f[3:0], 4'b1000});
      s.len  = LEN_W'(8);
    end else if (f <= WORD_W'(255)) begin
      s.bits = SEG_W'({f[7:0], 5'b10000});
      s.len  = LEN_W'(13);
    end else if (f <= WORD_W'(65535)) begin
      s.bits = SEG_W'({f[15:0], 6'b100000});
      s.len  = LEN_W'(22);
    end else begin
      s.bits = {f, 6'b000000};
      s.len  = LEN_W'(38);
    end
    return s;
  endfunction

endpackage

@@ sv/arbp_dp.sv @@
// ----------------------------------------------------------------------------
// arbp_dp
// datapath: item registers, bit accumulator and output register
// ----------------------------------------------------------------------------
module arbp_dp import arbp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tuser,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  logic              mode;
  logic [WORD_W-1:0] created;
  logic [WORD_W-1:0] axis [NUM_AXIS];
  logic [WORD_W-1:0] buttons;
  logic [ACC_W-1:0]  acc;
  logic [CNT_W-1:0]  cnt;
  seg_t              seg;

  always_comb begin
    seg = cmd.sel_button ? button_seg(buttons) : axis_seg(axis[0]);
  end

  assign status.mode     = mode;
  assign status.held     = (cnt != '0);
  assign status.out_free = !m_tvalid || m_tready;
  assign status.acc_lt16 = (cnt < CNT_W'(16));
  assign status.acc_ge8  = (cnt >= CNT_W'(8));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode    <= s_tuser;
      created <= s_tdata[WORD_W-1:0];
      for (int i = 0; i < NUM_AXIS; i++) begin
        axis[i] <= s_tdata[WORD_W*(i+1) +: WORD_W];
      end
      buttons <= s_tdata[WORD_W*(NUM_AXIS+1) +: WORD_W];
    end else begin
      if (cmd.emit_created) begin
        created <= {8'd0, created[WORD_W-1:8]};
      end
      if (cmd.load_seg) begin
        for (int i = 0; i < NUM_AXIS-1; i++) begin
          axis[i] <= axis[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.emit_partial) begin
      acc <= '0;
      cnt <= '0;
    end else if (cmd.emit_acc) begin
      acc <= {8'd0, acc[ACC_W-1:8]};
      cnt <= cnt - CNT_W'(8);
    end else if (cmd.load_seg) begin
      acc <= acc | (ACC_W'(seg.bits) << cnt[3:0]);
      cnt <= cnt + CNT_W'(seg.len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_partial || cmd.emit_created || cmd.emit_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_partial || cmd.emit_acc) begin
      m_tdata <= acc[7:0];
      m_tlast <= cmd.last;
    end else if (cmd.emit_created) begin
      m_tdata <= created[7:0];
      m_tlast <= 1'b0;
    end
  end

endmodule

@@ sv/arbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// arbp_ctrl
// controller: sequences partial byte, creation word bytes and bit segments
// ----------------------------------------------------------------------------
module arbp_ctrl import arbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PART,
    S_CRT,
    S_PACK
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [1:0]        crt_idx;
  logic [SIDX_W-1:0] seg_idx;
  logic              all_loaded;

  assign s_tready   = (state == S_IDLE);
  assign all_loaded = (seg_idx == SIDX_W'(NUM_SEG));

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.held) begin
          state_next = S_PART;
        end else if (status.mode) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CRT;
        end
      end
      S_PART: begin
        if (status.out_free) begin
          cmd.emit_partial = 1'b1;
          cmd.last         = status.mode;
          state_next       = status.mode ? S_IDLE : S_CRT;
        end
      end
      S_CRT: begin
        if (status.out_free) begin
          cmd.emit_created = 1'b1;
          if (crt_idx == 2'd3) begin
            state_next = S_PACK;
          end
        end
      end
      S_PACK: begin
        if (!all_loaded && status.acc_lt16) begin
          cmd.load_seg   = 1'b1;
          cmd.sel_button = (seg_idx == SIDX_W'(NUM_SEG - 1));
        end else if (status.acc_ge8) begin
          if (status.out_free) begin
            cmd.emit_acc = 1'b1;
            cmd.last     = all_loaded && status.acc_lt16;
            if (all_loaded && status.acc_lt16) begin
              state_next = S_IDLE;
            end
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      crt_idx <= '0;
      seg_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_START) begin
        crt_idx <= '0;
        seg_idx <= '0;
      end
      if (cmd.emit_created) begin
        crt_idx <= crt_idx + 2'd1;
      end
      if (cmd.load_seg) begin
        seg_idx <= seg_idx + SIDX_W'(1);
      end
    end
  end

endmodule

@@ sv/action_record_bit_packer_top.sv @@
// ----------------------------------------------------------------------------
// action_record_bit_packer_top
// packs action records into an lsb-first byte stream
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: created_time, axis_0..8, buttons; s_tuser: mode
// m_       out  m_tvalid/m_tready  m_tdata: out_byte; m_tlast: last_byte
//
// one transaction in at a time; the next is taken after the last byte is staged
// encode: capture and setup, a held partial byte if any, 4 creation bytes, then
// 10 segment loads interleaved with the packed bytes they produce
// flush: capture and setup, then the held partial byte if any, marked last
// sync reset clears the held bit buffer and the output valid flag
// output stalls hold back each byte emit; the byte register decouples sides
// ----------------------------------------------------------------------------
module action_record_bit_packer_top import arbp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // created_time, axis_0 .. axis_8, buttons
  input  logic [IN_W-1:0] s_tdata,
  // mode
  input  logic            s_tuser,
  output logic            m_tvalid,
  input  logic            m_tready,
  // out_byte
  output logic [7:0]      m_tdata,
  // last_byte
  output logic            m_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  arbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  arbp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ dv/action_record_bit_packer_top_tb.sv @@
// ----------------------------------------------------------------------------
// action_record_bit_packer_top_tb
// self-checking bench for the action record bit packer
//
// drives action records and flush requests into the input stream, predicts
// the packed lsb-first byte stream from its own copy of the held bits and
// compares every output transaction, data and last flag, in order. both
// sides idle at random; one long output stall and one full drain are forced.
// ----------------------------------------------------------------------------
module action_record_bit_packer_top_tb;
  import arbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit MODE_ENCODE = 1'b0;
  localparam bit MODE_FLUSH  = 1'b1;
  localparam int NUM_RANDOM  = 240;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int END_CYCLES  = 100;

  typedef struct {
    bit              mode;
    bit [WORD_W-1:0] created;
    bit [WORD_W-1:0] axis [NUM_AXIS];
    bit [WORD_W-1:0] buttons;
  } action_t;

  typedef struct {
    bit [7:0] data;
    bit       last;
  } packed_byte_t;

  class packed_byte_checker;
    packed_byte_t pending_bytes[$];
    packed_byte_t staged[$];
    bit [7:0]     held_bits;
    bit [2:0]     held_count;
    int           errors;
    int           records;
    int           flushes;
    int           bytes_checked;

    function new();
      held_bits  = '0;
      held_count = '0;
      errors     = 0;
      records    = 0;
      flushes    = 0;
      bytes_checked = 0;
    endfunction

    function void stage(bit [7:0] b);
      packed_byte_t p;
      p.data = b;
      p.last = 1'b0;
      staged.push_back(p);
    endfunction

    function void release_held();
      if (held_count != 0) begin
        stage(held_bits);
        held_bits  = '0;
        held_count = '0;
      end
    endfunction

    function void append_bits(bit [WORD_W-1:0] v, int n);
      int i;
      for (i = 0; i < n; i++) begin
        held_bits[held_count] = v[i];
        held_count = held_count + 1;
        if (held_count == 0) begin
          stage(held_bits);
          held_bits = '0;
        end
      end
    endfunction

    // prefix length code: zero run, a one unless the run is six, then payload
    function void append_buttons(bit [WORD_W-1:0] f);
      int zeros;
      int width;
      if (f == 0) begin
        zeros = 0; width = 0;
      end else if (f == 1) begin
        zeros = 1; width = 0;
      end else if (f <= 3) begin
        zeros = 2; width = 1;
      end else if (f <= 15) begin
        zeros = 3; width = 4;
      end else if (f <= 255) begin
        zeros = 4; width = 8;
      end else if (f <= 65535) begin
        zeros = 5; width = 16;
      end else begin
        zeros = 6; width = 32;
      end
      append_bits('0, zeros);
      if (zeros < 6) begin
        append_bits(1, 1);
      end
      append_bits(f, width);
    endfunction

    function void note_action(action_t a);
      int k;
      staged.delete();
      release_held();
      if (a.mode == MODE_FLUSH) begin
        flushes++;
      end else begin
        records++;
        for (k = 0; k < 4; k++) begin
          stage(a.created[8*k +: 8]);
        end
        for (k = 0; k < NUM_AXIS; k++) begin
          if (a.axis[k] == 0) begin
            append_bits(0, 1);
          end else begin
            append_bits(1, 1);
            append_bits(a.axis[k], WORD_W);
          end
        end
        append_buttons(a.buttons);
      end
      if (staged.size() > 0) begin
        staged[staged.size()-1].last = 1'b1;
      end
      foreach (staged[k]) begin
        pending_bytes.push_back(staged[k]);
      end
    endfunction

    function void check_byte(bit [7:0] data, bit last);
      packed_byte_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual data %02h last %0b",
                 $time, data, last);
        return;
      end
      want = pending_bytes.pop_front();
      if (want.data != data) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, want.data, data);
      end
      if (want.last != last) begin
        errors++;
        $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                 $time, want.last, last);
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            s_tuser = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [7:0]      m_tdata;
  logic            m_tlast;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  packed_byte_checker sb = new();

  action_record_bit_packer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [IN_W-1:0] pack_action(action_t a);
    logic [IN_W-1:0] v;
    int k;
    v = '0;
    v[0 +: WORD_W] = a.created;
    for (k = 0; k < NUM_AXIS; k++) begin
      v[WORD_W*(k+1) +: WORD_W] = a.axis[k];
    end
    v[WORD_W*(NUM_AXIS+1) +: WORD_W] = a.buttons;
    return v;
  endfunction

  function automatic bit [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [WORD_W-1:0] rand_buttons();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return $urandom_range(2, 3);
      3: return $urandom_range(4, 15);
      4: return $urandom_range(16, 255);
      5: return $urandom_range(256, 65535);
      6: return $urandom_range(65536, 32'hFFFF_FFFF);
      default: return rand_word();
    endcase
  endfunction

  function automatic action_t rand_action();
    action_t a;
    int k;
    a.mode    = ($urandom_range(99) < 15) ? MODE_FLUSH : MODE_ENCODE;
    a.created = rand_word();
    for (k = 0; k < NUM_AXIS; k++) begin
      a.axis[k] = ($urandom_range(2) == 0) ? '0 : rand_word();
    end
    a.buttons = rand_buttons();
    return a;
  endfunction

  function automatic action_t directed_action(bit mode, bit [WORD_W-1:0] created,
                                              bit [NUM_AXIS-1:0] live,
                                              bit [WORD_W-1:0] pattern,
                                              bit [WORD_W-1:0] buttons);
    action_t a;
    int k;
    a.mode    = mode;
    a.created = created;
    for (k = 0; k < NUM_AXIS; k++) begin
      a.axis[k] = live[k] ? ((pattern << k) | (pattern >> (WORD_W - k))) : '0;
    end
    a.buttons = buttons;
    return a;
  endfunction

  task automatic send_action(action_t a);
    s_tdata  <= pack_action(a);
    s_tuser  <= a.mode;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_action(a);
    if (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 8);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_byte(m_tdata, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush, all zero, all ones, every button range
    send_action(directed_action(MODE_FLUSH, '0, '0, '0, '0));
    send_action(directed_action(MODE_ENCODE, '0, '0, '0, 32'd0));
    send_action(directed_action(MODE_FLUSH, '1, '1, '1, '1));
    send_action(directed_action(MODE_ENCODE, '1, '1, '1, '1));
    send_action(directed_action(MODE_ENCODE, '1, '1, '1, '1));
    send_action(directed_action(MODE_ENCODE, 32'hA5A5_5A5A, 9'h155, 32'h5555_5555, 32'd1));
    send_action(directed_action(MODE_ENCODE, 32'h5A5A_A5A5, 9'h0AA, 32'hAAAA_AAAA, 32'd2));
    send_action(directed_action(MODE_ENCODE, 32'h0000_0001, 9'h001, 32'h8000_0000, 32'd3));
    send_action(directed_action(MODE_ENCODE, 32'h8000_0000, 9'h100, 32'h0000_0001, 32'd4));
    send_action(directed_action(MODE_ENCODE, 32'h1234_5678, 9'h0F0, 32'h0F0F_0F0F, 32'd15));
    send_action(directed_action(MODE_ENCODE, 32'h8765_4321, 9'h00F, 32'hF0F0_F0F0, 32'd16));
    send_action(directed_action(MODE_ENCODE, 32'hFFFF_0000, 9'h1E0, 32'hDEAD_BEEF, 32'd255));
    send_action(directed_action(MODE_ENCODE, 32'h0000_FFFF, 9'h01F, 32'h1357_9BDF, 32'd256));
    send_action(directed_action(MODE_ENCODE, 32'hCAFE_F00D, 9'h111, 32'h2468_ACE0, 32'd65535));
    send_action(directed_action(MODE_ENCODE, 32'h0F1E_2D3C, 9'h0C3, 32'hFFFF_FFFE, 32'd65536));
    send_action(directed_action(MODE_ENCODE, 32'hF0E1_D2C3, 9'h13C, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_action(directed_action(MODE_FLUSH, '0, '0, '0, '0));
    send_action(directed_action(MODE_FLUSH, '0, '0, '0, '0));
    send_action(directed_action(MODE_ENCODE, '0, '0, '0, 32'hAAAA_AAAA));
    send_action(directed_action(MODE_ENCODE, '1, '0, '0, 32'h5555_5555));

    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i == 60) begin
        hold_req = 1'b1;
      end
      if (i == 120) begin
        wait_drained();
      end
      quiet = (i >= 150 && i < 210);
      send_action(rand_action());
    end
    quiet = 1'b0;

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.errors++;
      $display("%0t: %0d expected bytes never arrived, next expected %02h",
               $time, sb.pending(), sb.pending_bytes[0].data);
    end
    $display("ran %0d action records and %0d flush requests, %0d output bytes checked",
             sb.records, sb.flushes, sb.bytes_checked);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
